/* hw/rtl/uv_sphere_mesh_generator_unit_defines.svh */
// Assertion macros shared by the UV-sphere mesh generator RTL.
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH

// Checks that a property holds in the same cycle as its trigger.
`define UVS_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("uvs same-cycle check failed");

// Checks that a property holds in the cycle after its trigger.
`define UVS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("uvs next-cycle check failed");

`endif

/* hw/rtl/uvs_pkg.sv */
// Shared types, constants and helper functions of the UV-sphere mesh generator.
package uvs_pkg;

    localparam int CFG_W          = 15;
    localparam int SEG_W          = 7;
    localparam int RAD_W          = 15;
    localparam int N_W            = 13;
    localparam int CORNER_W       = 13;
    localparam int TEX_W          = 16;
    localparam int POS_W          = 16;
    localparam int DEN_W          = 8;
    localparam int SIN_W          = 17;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int MAX_SEGMENTS   = 64;
    localparam int MIN_STACKS     = 2;
    localparam int MIN_SLICES     = 3;
    localparam int HORNER_STEPS   = 4;

    // Sine polynomial coefficients in Q2.30, highest order first.
    localparam logic [31:0] SINE_K9 = 32'd172272;
    localparam logic [31:0] HORNER_K [HORNER_STEPS] = '{
        32'd5026993, 32'd85569305, 32'd693598668, 32'd1686629713
    };
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef enum logic [1:0] {
        CFG_STACK_COUNT = 2'd0,
        CFG_SLICE_COUNT = 2'd1,
        CFG_RADIUS      = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_VERTEX   = 1'b0,
        OP_TRIANGLE = 1'b1
    } op_t;

    // Per-request context carried alongside the arithmetic pipeline.
    typedef struct packed {
        op_t                 op;
        logic                ok;
        logic                top;
        logic                bot;
        logic                band;
        logic [CORNER_W-1:0] cor_a;
        logic [CORNER_W-1:0] cor_b;
        logic [CORNER_W-1:0] cor_c;
        logic [TEX_W-1:0]    tex_u;
        logic [TEX_W-1:0]    tex_v;
    } item_t;

    // Clamp a segment count into [lo, MAX_SEGMENTS].
    function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] v,
                                                   input logic [SEG_W-1:0] lo);
        logic [SEG_W-1:0] res;
        res = v;
        if (v < lo) begin
            res = lo;
        end else if (v > SEG_W'(MAX_SEGMENTS)) begin
            res = SEG_W'(MAX_SEGMENTS);
        end
        return res;
    endfunction

    // Round a product half away from zero by sh bits and saturate to 16 bits.
    function automatic logic [POS_W-1:0] sat_round(input logic signed [49:0] prod,
                                                   input int unsigned sh);
        logic        neg;
        logic [49:0] mag;
        logic [49:0] q;
        logic [POS_W-1:0] res;
        neg = prod[49];
        mag = neg ? 50'(-prod) : 50'(prod);
        q   = (mag + (50'd1 << (sh - 1))) >> sh;
        if (neg) begin
            res = (q > 50'd32768) ? 16'h8000 : POS_W'(50'd0 - q);
        end else begin
            res = (q > 50'd32767) ? 16'h7FFF : q[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/uvs_div_cell.sv */
// One restoring division step: produces one quotient bit per lane per cycle while en is high.
module uvs_div_cell #(
    parameter int NW    = 13,
    parameter int DW    = 8,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [LANES-1:0][NW-1:0]   in_num,
    input  logic [LANES-1:0][DW-1:0]   in_rem,
    input  logic [LANES-1:0][NW-1:0]   in_quo,
    input  logic [LANES-1:0][DW-1:0]   in_den,
    input  logic [SW-1:0]              in_side,
    output logic                       out_vld,
    output logic [LANES-1:0][NW-1:0]   out_num,
    output logic [LANES-1:0][DW-1:0]   out_rem,
    output logic [LANES-1:0][NW-1:0]   out_quo,
    output logic [LANES-1:0][DW-1:0]   out_den,
    output logic [SW-1:0]              out_side
);

    logic [LANES-1:0][NW-1:0] num_next;
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][NW-1:0] quo_next;
    logic                     vld_reg;

    // Shift in the next numerator bit and subtract the divisor when it fits.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [DW:0] t;
            logic        ge;
            t           = {in_rem[l], in_num[l][NW-1]};
            ge          = (t >= {1'b0, in_den[l]});
            rem_next[l] = ge ? DW'(t - {1'b0, in_den[l]}) : t[DW-1:0];
            num_next[l] = {in_num[l][NW-2:0], 1'b0};
            quo_next[l] = {in_quo[l][NW-2:0], ge};
        end
    end

    // Valid bit of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    // Payload of this cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_num  <= num_next;
            out_rem  <= rem_next;
            out_quo  <= quo_next;
            out_den  <= in_den;
            out_side <= in_side;
        end
    end

    assign out_vld = vld_reg;

endmodule

/* hw/rtl/uvs_divider.sv */
// Pipelined multi-lane divider built from a chain of restoring division cells.
module uvs_divider #(
    parameter int NW    = 13,
    parameter int DW    = 8,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [LANES-1:0][NW-1:0]   in_num,
    input  logic [LANES-1:0][DW-1:0]   in_den,
    input  logic [SW-1:0]              in_side,
    output logic                       out_vld,
    output logic [LANES-1:0][NW-1:0]   out_quo,
    output logic [LANES-1:0][DW-1:0]   out_rem,
    output logic [SW-1:0]              out_side
);

    logic [NW:0]                      vld;
    logic [NW:0][LANES-1:0][NW-1:0]   num;
    logic [NW:0][LANES-1:0][DW-1:0]   rem;
    logic [NW:0][LANES-1:0][NW-1:0]   quo;
    logic [NW:0][LANES-1:0][DW-1:0]   den;
    logic [NW:0][SW-1:0]              side;

    // Chain head: empty remainder and quotient.
    assign vld[0]  = in_vld;
    assign num[0]  = in_num;
    assign rem[0]  = '0;
    assign quo[0]  = '0;
    assign den[0]  = in_den;
    assign side[0] = in_side;

    // One cell per quotient bit.
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        uvs_div_cell #(
            .NW    (NW),
            .DW    (DW),
            .LANES (LANES),
            .SW    (SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (vld[i]),
            .in_num   (num[i]),
            .in_rem   (rem[i]),
            .in_quo   (quo[i]),
            .in_den   (den[i]),
            .in_side  (side[i]),
            .out_vld  (vld[i+1]),
            .out_num  (num[i+1]),
            .out_rem  (rem[i+1]),
            .out_quo  (quo[i+1]),
            .out_den  (den[i+1]),
            .out_side (side[i+1])
        );
    end

    assign out_vld  = vld[NW];
    assign out_quo  = quo[NW];
    assign out_rem  = rem[NW];
    assign out_side = side[NW];

endmodule

/* hw/rtl/uvs_sine.sv */
// Pipelined multi-lane sine: quarter-wave fold, Horner chain, rounding to signed Q2.15.
module uvs_sine #(
    parameter int ANGLE_BITS = 16,
    parameter int LANES      = 4,
    parameter int SW         = 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_vld,
    input  logic [LANES-1:0][ANGLE_BITS-1:0]   in_phase,
    input  logic [SW-1:0]                      in_side,
    output logic                               out_vld,
    output logic [LANES-1:0][uvs_pkg::SIN_W-1:0] out_sin,
    output logic [SW-1:0]                      out_side
);

    import uvs_pkg::*;

    localparam int NH = HORNER_STEPS;

    logic [LANES-1:0][30:0]         x0_next;
    logic [LANES-1:0]               neg0_next;
    logic [LANES-1:0][30:0]         x0_reg;
    logic [LANES-1:0]               neg0_reg;
    logic                           v0_reg;
    logic [SW-1:0]                  s0_reg;

    logic [NH:0][LANES-1:0][30:0]   hx_reg;
    logic [NH:0][LANES-1:0][30:0]   hx2_reg;
    logic [NH:0][LANES-1:0]         hneg_reg;
    logic [NH:0]                    hv_reg;
    logic [NH:0][SW-1:0]            hs_reg;
    logic [NH-1:0][LANES-1:0][31:0] hacc_reg;

    logic [LANES-1:0][30:0]         x2_next;
    logic [LANES-1:0][SIN_W-1:0]    sin_next;
    logic [LANES-1:0][SIN_W-1:0]    sin_reg;
    logic                           vo_reg;
    logic [SW-1:0]                  so_reg;

    // Fold the phase into the first quadrant.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [1:0]  quad;
            logic [29:0] r30;
            quad         = in_phase[l][ANGLE_BITS-1 -: 2];
            r30          = 30'(in_phase[l][ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
            x0_next[l]   = quad[0] ? (ONE_Q30 - 31'(r30)) : 31'(r30);
            neg0_next[l] = quad[1];
        end
    end

    // Square of the folded argument.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x2_next[l] = 31'((62'(x0_reg[l]) * 62'(x0_reg[l])) >> 30);
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            hv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_vld;
            hv_reg[0] <= v0_reg;
        end
    end

    // Payload of the front stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg      <= x0_next;
            neg0_reg    <= neg0_next;
            s0_reg      <= in_side;
            hx_reg[0]   <= x0_reg;
            hx2_reg[0]  <= x2_next;
            hneg_reg[0] <= neg0_reg;
            hs_reg[0]   <= s0_reg;
        end
    end

    // Horner cells: acc = K - acc * x^2, one coefficient per cell.
    for (genvar h = 0; h < NH; h++)
    begin : g_horner
        logic [LANES-1:0][31:0] acc_in;
        logic [LANES-1:0][31:0] acc_next;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                acc_in[l]   = (h == 0) ? SINE_K9 : hacc_reg[(h == 0) ? 0 : h - 1][l];
                acc_next[l] = HORNER_K[h]
                            - 32'((63'(acc_in[l]) * 63'(hx2_reg[h][l])) >> 30);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hv_reg[h+1] <= 1'b0;
            end
            else if (en)
            begin
                hv_reg[h+1] <= hv_reg[h];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hacc_reg[h]   <= acc_next;
                hx_reg[h+1]   <= hx_reg[h];
                hx2_reg[h+1]  <= hx2_reg[h];
                hneg_reg[h+1] <= hneg_reg[h];
                hs_reg[h+1]   <= hs_reg[h];
            end
        end
    end

    // Final product, cap at one, round to signed Q2.15 and restore the sign.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [62:0]      s;
            logic [SIN_W-1:0] sq;
            s = (63'(hacc_reg[NH-1][l]) * 63'(hx_reg[NH][l])) >> 30;
            if (s > 63'(ONE_Q30))
            begin
                s = 63'(ONE_Q30);
            end
            sq          = SIN_W'((s + 63'd16384) >> 15);
            sin_next[l] = hneg_reg[NH][l] ? SIN_W'(-sq) : sq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= hv_reg[NH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            so_reg  <= hs_reg[NH];
        end
    end

    assign out_vld  = vo_reg;
    assign out_sin  = sin_reg;
    assign out_side = so_reg;

endmodule

/* hw/rtl/uv_sphere_mesh_generator_unit.sv */
// Top level of the UV-sphere mesh generator: request decode, dividers, sine, scaling.
//
//  Channel   Direction  Handshake                       Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready   tuser: op, tdata: item_number
//  m_axis    out        m_axis_tvalid / m_axis_tready   tuser: valid_res, tdata: mesh data
//  cfg       in         cfg_we (no back-pressure)       cfg_index, cfg_wdata
//
// One request is accepted per cycle unless the output stalls; each result passes the
// decode register, both divider chains, the sine stages and the scaling/output registers.
// The whole pipeline advances together and halts only while a result waits at the output.
// Reset clears the valid bits and loads the register defaults; no clearing pass is needed.
module uv_sphere_mesh_generator_unit #(
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // [12:0] item_number, rest zero
    input  logic                       s_axis_tuser,   // [0] op
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] tex_u, [79:64] tex_v,
    // [92:80] corner_a, [105:93] corner_b, [118:106] corner_c, [119] zero
    output logic [119:0]               m_axis_tdata,
    output logic                       m_axis_tuser,   // [0] valid_res
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]  cfg_wdata
);

    import uvs_pkg::*;

    localparam int D2_NW = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 8;
    localparam int IT_W  = $bits(item_t);

    logic [SEG_W-1:0] stack_count_reg;
    logic [SEG_W-1:0] slice_count_reg;
    logic [RAD_W-1:0] radius_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= SEG_W'(20);
            slice_count_reg <= SEG_W'(20);
            radius_reg      <= RAD_W'(2560);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STACK_COUNT: stack_count_reg <= cfg_wdata[SEG_W-1:0];
                CFG_SLICE_COUNT: slice_count_reg <= cfg_wdata[SEG_W-1:0];
                CFG_RADIUS:      radius_reg      <= cfg_wdata[RAD_W-1:0];
                default:         ;
            endcase
        end
    end

    // Mesh dimensions derived from the registers.
    logic [SEG_W-1:0] stacks;
    logic [SEG_W-1:0] slices;
    logic [DEN_W-1:0] ring;
    logic [DEN_W-1:0] slices2;
    logic [DEN_W-1:0] stacks2;
    logic [14:0]      nverts;
    logic [14:0]      ntris;
    logic [14:0]      bands;

    assign stacks  = clamp_seg(stack_count_reg, SEG_W'(MIN_STACKS));
    assign slices  = clamp_seg(slice_count_reg, SEG_W'(MIN_SLICES));
    assign ring    = {1'b0, slices} + DEN_W'(1);
    assign slices2 = {slices, 1'b0};
    assign stacks2 = {stacks, 1'b0};
    assign nverts  = 15'd2 + 15'(stacks - SEG_W'(1)) * 15'(ring);
    assign ntris   = 15'(slices2) * 15'(stacks - SEG_W'(1));
    assign bands   = 15'(slices2) * 15'(stacks - SEG_W'(2));

    // The whole pipeline moves unless a result is held at the output.
    logic en;
    logic m_tvalid_reg;

    assign en            = !m_tvalid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Request decode: range check, poles and cap triangles.
    item_t            e_item_next;
    logic [N_W-1:0]   e_num_next;
    logic [DEN_W-1:0] e_den_next;

    always_comb
    begin
        logic [N_W-1:0] n;
        logic [14:0]    n15;
        logic [14:0]    i2;
        logic [14:0]    bb;
        n           = s_axis_tdata[N_W-1:0];
        n15         = 15'(n);
        i2          = n15 - 15'(slices) - bands;
        bb          = nverts - 15'd1 - 15'(ring) + i2;
        e_item_next = '0;
        e_item_next.op = op_t'(s_axis_tuser);
        if (op_t'(s_axis_tuser) == OP_VERTEX)
        begin
            e_item_next.ok  = (n15 < nverts);
            e_item_next.top = (n == '0);
            e_item_next.bot = (n15 == nverts - 15'd1);
            e_num_next      = n - N_W'(1);
            e_den_next      = ring;
        end
        else
        begin
            e_item_next.ok = (n15 < ntris);
            if (n15 < 15'(slices))
            begin
                e_item_next.cor_b = CORNER_W'(n + N_W'(2));
                e_item_next.cor_c = CORNER_W'(n + N_W'(1));
            end
            else if ((n15 - 15'(slices)) < bands)
            begin
                e_item_next.band = 1'b1;
            end
            else
            begin
                e_item_next.cor_a = CORNER_W'(nverts - 15'd1);
                e_item_next.cor_b = bb[CORNER_W-1:0];
                e_item_next.cor_c = CORNER_W'(bb + 15'd1);
            end
            e_num_next = n - N_W'(slices);
            e_den_next = slices2;
        end
    end

    logic             e_vld_reg;
    item_t            e_item_reg;
    logic [N_W-1:0]   e_num_reg;
    logic [DEN_W-1:0] e_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_item_reg <= e_item_next;
            e_num_reg  <= e_num_next;
            e_den_reg  <= e_den_next;
        end
    end

    // Ring / column split of the vertex or band triangle number.
    logic                     d1_vld;
    logic [0:0][N_W-1:0]      d1_quo;
    logic [0:0][DEN_W-1:0]    d1_rem;
    logic [IT_W-1:0]          d1_side;

    uvs_divider #(
        .NW    (N_W),
        .DW    (DEN_W),
        .LANES (1),
        .SW    (IT_W)
    ) u_div_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (e_vld_reg),
        .in_num   (e_num_reg),
        .in_den   (e_den_reg),
        .in_side  (e_item_reg),
        .out_vld  (d1_vld),
        .out_quo  (d1_quo),
        .out_rem  (d1_rem),
        .out_side (d1_side)
    );

    // Band triangle corners and angle / texture numerators.
    item_t                        p_item_next;
    logic [3:0][D2_NW-1:0]        p_num_next;
    logic [3:0][DEN_W-1:0]        p_den_next;

    always_comb
    begin
        logic [SEG_W-1:0] q;
        logic [SEG_W-1:0] yv;
        logic [SEG_W-1:0] xv;
        logic [15:0]      up;
        logic [15:0]      dn;
        q    = d1_quo[0][SEG_W-1:0];
        yv   = q + SEG_W'(1);
        xv   = d1_rem[0][SEG_W-1:0];
        up   = 16'd1 + 16'(q) * 16'(ring) + 16'(d1_rem[0][DEN_W-1:1]);
        dn   = up + 16'(ring);
        p_item_next = item_t'(d1_side);
        if (p_item_next.op == OP_TRIANGLE && p_item_next.band)
        begin
            p_item_next.cor_a = d1_rem[0][0] ? dn[CORNER_W-1:0] : up[CORNER_W-1:0];
            p_item_next.cor_b = CORNER_W'(up + 16'd1);
            p_item_next.cor_c = d1_rem[0][0] ? CORNER_W'(dn + 16'd1) : dn[CORNER_W-1:0];
        end
        p_num_next[0] = (D2_NW'(yv) << ANGLE_BITS) + D2_NW'(stacks);
        p_den_next[0] = stacks2;
        p_num_next[1] = (D2_NW'(xv) << (ANGLE_BITS + 1)) + D2_NW'(slices);
        p_den_next[1] = slices2;
        p_num_next[2] = (D2_NW'(xv) << 17) + D2_NW'(slices);
        p_den_next[2] = slices2;
        p_num_next[3] = (D2_NW'(yv) << 17) + D2_NW'(stacks);
        p_den_next[3] = stacks2;
    end

    logic                     p_vld_reg;
    item_t                    p_item_reg;
    logic [3:0][D2_NW-1:0]    p_num_reg;
    logic [3:0][DEN_W-1:0]    p_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_item_reg <= p_item_next;
            p_num_reg  <= p_num_next;
            p_den_reg  <= p_den_next;
        end
    end

    // Rounded divisions: phi, theta, tex_u, tex_v.
    logic                     d2_vld;
    logic [3:0][D2_NW-1:0]    d2_quo;
    logic [3:0][DEN_W-1:0]    d2_rem;
    logic [IT_W-1:0]          d2_side;

    uvs_divider #(
        .NW    (D2_NW),
        .DW    (DEN_W),
        .LANES (4),
        .SW    (IT_W)
    ) u_div_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p_vld_reg),
        .in_num   (p_num_reg),
        .in_den   (p_den_reg),
        .in_side  (p_item_reg),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_rem  (d2_rem),
        .out_side (d2_side)
    );

    // Phases for sin/cos of phi and theta; texture coordinates saturate at one.
    logic [3:0][ANGLE_BITS-1:0] sn_phase;
    item_t                      sn_item;
    logic [ANGLE_BITS-1:0]      quarter;

    assign quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    always_comb
    begin
        sn_phase[0] = d2_quo[0][ANGLE_BITS-1:0];
        sn_phase[1] = d2_quo[0][ANGLE_BITS-1:0] + quarter;
        sn_phase[2] = d2_quo[1][ANGLE_BITS-1:0];
        sn_phase[3] = d2_quo[1][ANGLE_BITS-1:0] + quarter;
        sn_item       = item_t'(d2_side);
        sn_item.tex_u = (|d2_quo[2][D2_NW-1:TEX_W]) ? '1 : d2_quo[2][TEX_W-1:0];
        sn_item.tex_v = (|d2_quo[3][D2_NW-1:TEX_W]) ? '1 : d2_quo[3][TEX_W-1:0];
    end

    logic                   sn_vld;
    logic [3:0][SIN_W-1:0]  sn;
    logic [IT_W-1:0]        sn_side;

    uvs_sine #(
        .ANGLE_BITS (ANGLE_BITS),
        .LANES      (4),
        .SW         (IT_W)
    ) u_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d2_vld),
        .in_phase (sn_phase),
        .in_side  (sn_item),
        .out_vld  (sn_vld),
        .out_sin  (sn),
        .out_side (sn_side)
    );

    // Scale by the radius: r*sin(phi) and r*cos(phi).
    logic                      m1_vld_reg;
    item_t                     m1_item_reg;
    logic signed [32:0]        rsp_reg;
    logic signed [32:0]        rcp_reg;
    logic signed [SIN_W-1:0]   st_reg;
    logic signed [SIN_W-1:0]   ct_reg;

    // Then by sin(theta) and cos(theta).
    logic                      m2_vld_reg;
    item_t                     m2_item_reg;
    logic signed [49:0]        px_reg;
    logic signed [49:0]        pz_reg;
    logic signed [32:0]        py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_vld_reg <= sn_vld;
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_item_reg <= item_t'(sn_side);
            rsp_reg     <= $signed({1'b0, radius_reg}) * $signed(sn[0]);
            rcp_reg     <= $signed({1'b0, radius_reg}) * $signed(sn[1]);
            st_reg      <= $signed(sn[2]);
            ct_reg      <= $signed(sn[3]);
            m2_item_reg <= m1_item_reg;
            px_reg      <= rsp_reg * ct_reg;
            pz_reg      <= rsp_reg * st_reg;
            py_reg      <= rcp_reg;
        end
    end

    // Result assembly: poles, ring vertices, triangles; zero when out of range.
    logic [POS_W-1:0]    o_px;
    logic [POS_W-1:0]    o_py;
    logic [POS_W-1:0]    o_pz;
    logic [TEX_W-1:0]    o_u;
    logic [TEX_W-1:0]    o_v;
    logic [CORNER_W-1:0] o_a;
    logic [CORNER_W-1:0] o_b;
    logic [CORNER_W-1:0] o_c;

    always_comb
    begin
        o_px = '0;
        o_py = '0;
        o_pz = '0;
        o_u  = '0;
        o_v  = '0;
        o_a  = '0;
        o_b  = '0;
        o_c  = '0;
        if (m2_item_reg.ok)
        begin
            if (m2_item_reg.op == OP_VERTEX)
            begin
                if (m2_item_reg.top)
                begin
                    o_py = {1'b0, radius_reg};
                    o_u  = 16'h8000;
                end
                else if (m2_item_reg.bot)
                begin
                    o_py = POS_W'(16'd0 - {1'b0, radius_reg});
                    o_u  = 16'h8000;
                    o_v  = 16'hFFFF;
                end
                else
                begin
                    o_px = sat_round(px_reg, 30);
                    o_py = sat_round(50'(py_reg), 15);
                    o_pz = sat_round(pz_reg, 30);
                    o_u  = m2_item_reg.tex_u;
                    o_v  = m2_item_reg.tex_v;
                end
            end
            else
            begin
                o_a = m2_item_reg.cor_a;
                o_b = m2_item_reg.cor_b;
                o_c = m2_item_reg.cor_c;
            end
        end
    end

    logic [119:0] m_tdata_reg;
    logic         m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= {1'b0, o_c, o_b, o_a, o_v, o_u, o_pz, o_py, o_px};
            m_tuser_reg <= m2_item_reg.ok;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // Checks.
    `include "uv_sphere_mesh_generator_unit_defines.svh"

    `UVS_ASSERT_SAME(a_invalid_is_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `UVS_ASSERT_SAME(a_corner_in_mesh, m_axis_tvalid && m_axis_tuser, (15'(m_axis_tdata[92:80]) < nverts) && (15'(m_axis_tdata[105:93]) < nverts) && (15'(m_axis_tdata[118:106]) < nverts))
    `UVS_ASSERT_SAME(a_sine_bounded, sn_vld, ($signed(sn[0]) <= 17'sd32768) && ($signed(sn[0]) >= -17'sd32768) && ($signed(sn[3]) <= 17'sd32768) && ($signed(sn[3]) >= -17'sd32768))
    `UVS_ASSERT_NEXT(a_stall_holds_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule
